FILE: rtl/ubac_pkg.sv
// Shared constants, action codes and helpers for the unaligned byte access block.
`default_nettype none
package ubac_pkg;

  // Storage size in 32-bit words (power of two).
  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned WORD_AW   = $clog2(MEM_WORDS);
  localparam int unsigned BYTE_AW   = WORD_AW + 2;

  // Field widths of one item.
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned DATA_W = 32;

  // Input tdata layout, lowest field first, padded to whole bytes.
  localparam int unsigned IN_ADDR_LO  = 0;
  localparam int unsigned IN_SRC_LO   = IN_ADDR_LO + ADDR_W;
  localparam int unsigned IN_LEN_LO   = IN_SRC_LO + ADDR_W;
  localparam int unsigned IN_WDATA_LO = IN_LEN_LO + LEN_W;
  localparam int unsigned IN_USED_W   = IN_WDATA_LO + DATA_W;
  localparam int unsigned IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_RD_BYTE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WR_BYTE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RD_WORD = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WR_WORD = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COPY    = 3'd4;

  localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00ff;

  // Byte address wraps at the end of storage.
  function automatic logic [BYTE_AW-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W+BYTE_AW-1:0] ext;
    ext = {{BYTE_AW{1'b0}}, a};
    return ext[BYTE_AW-1:0];
  endfunction

  // Pull one byte lane out of a word.
  function automatic logic [7:0] get_lane(input logic [DATA_W-1:0] w, input logic [1:0] lane);
    logic [DATA_W-1:0] sh;
    sh = w >> {lane, 3'b000};
    return sh[7:0];
  endfunction

  // Replace one byte lane of a word.
  function automatic logic [DATA_W-1:0] put_lane(input logic [DATA_W-1:0] w,
                                                  input logic [1:0]        lane,
                                                  input logic [7:0]        b);
    logic [DATA_W-1:0] mask;
    mask = BYTE_MASK << {lane, 3'b000};
    return (w & ~mask) | ({24'b0, b} << {lane, 3'b000});
  endfunction

endpackage
`default_nettype wire

FILE: rtl/unaligned_byte_access_and_copy_top.sv
// Top level: byte-addressed access and copy engine over a 32-bit word RAM.
//
// Input channel (s_axis): one item per action. tuser carries the action
// (read byte, write byte, read word, write word, copy); tdata carries the
// byte address or copy destination, copy source, copy length and write data.
// Output channel (m_axis): exactly one item per input item. tdata is the read
// byte (zero-extended) or the assembled little-endian word, zero otherwise;
// tuser is the completed flag (low only for unknown action codes).
//
// Throughput: one item at a time; stored data lives in one word RAM with a
// single read and a single write port. Byte accesses read their word, then
// return its lane or write it back merged. Aligned word writes go straight
// to the RAM; other word accesses read one word, or two across a boundary,
// and unaligned writes then write both. A copy takes each byte as a source
// read, destination read and write back, serialized so every read sees the
// previous write. Unknown actions and zero-length copies skip to the result.
// s_axis_tready is high whenever the engine is idle, even while an earlier
// result still waits in the output register; when the receiver stalls, a
// finished item waits in its last state until the output register frees up.
// Reset clears the control state and the output register; RAM contents are
// undefined until written and need no clearing pass.
`default_nettype none
module unaligned_byte_access_and_copy_top (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // tdata from bit 0: address[11:0], source_address[23:12], length[36:24],
  // write_data[68:37], zero padding[71:69]
  input  wire [ubac_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: action[2:0]
  input  wire [ubac_pkg::ACT_W-1:0]           s_axis_tuser,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: read_data[31:0]
  output logic [ubac_pkg::DATA_W-1:0]         m_axis_tdata,
  // tuser: completed[0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready
);

  localparam int unsigned WAW = ubac_pkg::WORD_AW;
  localparam int unsigned BAW = ubac_pkg::BYTE_AW;
  localparam int unsigned DW  = ubac_pkg::DATA_W;
  localparam int unsigned LW  = ubac_pkg::LEN_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,     // read of first word in flight
    S_RD1,     // first word back, maybe fetch second
    S_RD2,     // second word back
    S_WR0,     // aligned word write
    S_WR1,     // upper word of an unaligned write
    S_CP_SRC,  // copy: fetch source word
    S_CP_DST,  // copy: source back, fetch destination word
    S_CP_WR,   // copy: merge byte and write back
    S_RESP     // hand result to output register
  } state_e;

  state_e                          state_q, state_d;
  logic [ubac_pkg::ACT_W-1:0]      act_q, act_d;
  logic [BAW-1:0]                  addr_q, addr_d;
  logic [BAW-1:0]                  src_q, src_d;
  logic [LW-1:0]                   len_q, len_d;
  logic [DW-1:0]                   wdata_q, wdata_d;
  logic [DW-1:0]                   word0_q, word0_d;
  logic [DW-1:0]                   word1_q, word1_d;
  logic [7:0]                      byte_q, byte_d;
  logic [DW-1:0]                   res_q, res_d;
  logic                            done_q, done_d;
  logic                            m_valid_q, m_valid_d;
  logic [DW-1:0]                   m_data_q, m_data_d;
  logic                            m_user_q, m_user_d;

  // RAM port signals
  logic           ram_we, ram_re;
  logic [WAW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]  ram_wdata, ram_rdata;

  logic [WAW-1:0] wrd0, wrd1;
  logic [1:0]     lane;
  logic [BAW-1:0] in_addr;
  logic [2*DW-1:0] pair, pair_mask, pair_new;

  assign wrd0    = addr_q[BAW-1:2];
  assign wrd1    = WAW'(wrd0 + 1'b1);
  assign lane    = addr_q[1:0];
  assign in_addr = ubac_pkg::wrap_addr(
                     s_axis_tdata[ubac_pkg::IN_ADDR_LO +: ubac_pkg::ADDR_W]);

  // Two adjacent words seen as one little-endian window.
  assign pair      = {ram_rdata, word0_q};
  assign pair_mask = {{DW{1'b0}}, {DW{1'b1}}} << {lane, 3'b000};
  assign pair_new  = (pair & ~pair_mask) | ({{DW{1'b0}}, wdata_q} << {lane, 3'b000});

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    addr_d    = addr_q;
    src_d     = src_q;
    len_d     = len_q;
    wdata_d   = wdata_q;
    word0_d   = word0_q;
    word1_d   = word1_q;
    byte_d    = byte_q;
    res_d     = res_q;
    done_d    = done_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    ram_we    = 1'b0;
    ram_waddr = wrd0;
    ram_wdata = word0_q;
    ram_re    = 1'b0;
    ram_raddr = wrd0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d   = s_axis_tuser;
          addr_d  = in_addr;
          src_d   = ubac_pkg::wrap_addr(
                      s_axis_tdata[ubac_pkg::IN_SRC_LO +: ubac_pkg::ADDR_W]);
          len_d   = s_axis_tdata[ubac_pkg::IN_LEN_LO +: LW];
          wdata_d = s_axis_tdata[ubac_pkg::IN_WDATA_LO +: DW];
          res_d   = '0;
          done_d  = 1'b1;
          case (s_axis_tuser)
            ubac_pkg::ACT_RD_BYTE,
            ubac_pkg::ACT_WR_BYTE,
            ubac_pkg::ACT_RD_WORD: begin
              state_d = S_RD0;
            end
            ubac_pkg::ACT_WR_WORD: begin
              state_d = (in_addr[1:0] == 2'b00) ? S_WR0 : S_RD0;
            end
            ubac_pkg::ACT_COPY: begin
              state_d = (s_axis_tdata[ubac_pkg::IN_LEN_LO +: LW] == '0) ? S_RESP : S_CP_SRC;
            end
            default: begin
              done_d  = 1'b0;
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = wrd0;
        state_d   = S_RD1;
      end

      S_RD1: begin
        word0_d = ram_rdata;
        case (act_q)
          ubac_pkg::ACT_RD_BYTE: begin
            res_d   = {24'b0, ubac_pkg::get_lane(ram_rdata, lane)};
            state_d = S_RESP;
          end
          ubac_pkg::ACT_WR_BYTE: begin
            ram_we    = 1'b1;
            ram_waddr = wrd0;
            ram_wdata = ubac_pkg::put_lane(ram_rdata, lane, wdata_q[7:0]);
            state_d   = S_RESP;
          end
          default: begin
            // word access: aligned read finishes here, anything else spans two words
            if (act_q == ubac_pkg::ACT_RD_WORD && lane == 2'b00) begin
              res_d   = ram_rdata;
              state_d = S_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = wrd1;
              state_d   = S_RD2;
            end
          end
        endcase
      end

      S_RD2: begin
        if (act_q == ubac_pkg::ACT_RD_WORD) begin
          res_d   = DW'(pair >> {lane, 3'b000});
          state_d = S_RESP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = wrd0;
          ram_wdata = pair_new[DW-1:0];
          word1_d   = pair_new[2*DW-1:DW];
          state_d   = S_WR1;
        end
      end

      S_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = wrd0;
        ram_wdata = wdata_q;
        state_d   = S_RESP;
      end

      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = wrd1;
        ram_wdata = word1_q;
        state_d   = S_RESP;
      end

      S_CP_SRC: begin
        ram_re    = 1'b1;
        ram_raddr = src_q[BAW-1:2];
        state_d   = S_CP_DST;
      end

      S_CP_DST: begin
        byte_d    = ubac_pkg::get_lane(ram_rdata, src_q[1:0]);
        ram_re    = 1'b1;
        ram_raddr = wrd0;
        state_d   = S_CP_WR;
      end

      S_CP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wrd0;
        ram_wdata = ubac_pkg::put_lane(ram_rdata, lane, byte_q);
        src_d     = BAW'(src_q + 1'b1);
        addr_d    = BAW'(addr_q + 1'b1);
        len_d     = LW'(len_q - 1'b1);
        state_d   = (len_q == LW'(1)) ? S_RESP : S_CP_SRC;
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          m_user_d  = done_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_q     <= '0;
      addr_q    <= '0;
      src_q     <= '0;
      len_q     <= '0;
      wdata_q   <= '0;
      word0_q   <= '0;
      word1_q   <= '0;
      byte_q    <= '0;
      res_q     <= '0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      addr_q    <= addr_d;
      src_q     <= src_d;
      len_q     <= len_d;
      wdata_q   <= wdata_d;
      word0_q   <= word0_d;
      word1_q   <= word1_d;
      byte_q    <= byte_d;
      res_q     <= res_d;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  ubac_ram #(
    .WIDTH(DW),
    .DEPTH(ubac_pkg::MEM_WORDS)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
`default_nettype wire

FILE: rtl/ubac_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ubac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ubac_checker.sv
// Port-level checker for the unaligned byte access block, bound to its top level.
`default_nettype none
module ubac_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire [ubac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire [ubac_pkg::ACT_W-1:0]       s_axis_tuser,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire [ubac_pkg::DATA_W-1:0]      m_axis_tdata,
  input wire                             m_axis_tuser,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Result is held until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // One item at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // No result can appear the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // Unknown actions return zero data.
  a_not_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero data on an uncompleted action");

endmodule

bind unaligned_byte_access_and_copy_top ubac_checker u_ubac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);
`default_nettype wire
